// File: rtl/fgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgs_pkg
// Shared types and constants for the finger galloping search block.
// ----------------------------------------------------------------------------
package fgs_pkg;

	// Field widths of the request and response items
	localparam int unsigned CMD_W    = 1;
	localparam int unsigned IDX_W    = 12;
	localparam int unsigned KEY_W    = 64;
	localparam int unsigned STATUS_W = 2;

	// Configuration port
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned COUNT_W  = 13;

	// Register index, taken from the word address bit of paddr
	typedef enum logic {
		REG_ENTRY_COUNT = 1'b0,
		REG_NONE        = 1'b1
	} reg_idx_t;

	// Request command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// Response status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_FOUND  = 2'd0,
		STS_BEFORE = 2'd1,
		STS_EMPTY  = 2'd2
	} status_t;

	// Search sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_HI,
		S_CHK_HI,
		S_CHK_LO,
		S_UP,
		S_UP_CHK,
		S_DN,
		S_DN_CHK,
		S_BIS,
		S_BIS_CHK,
		S_FIN
	} state_t;

	// Configuration write event toward the search core
	typedef struct packed {
		logic               wr;
		logic [COUNT_W-1:0] count;
	} cfg_t;

endpackage

// File: rtl/fgs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgs_req_if / fgs_rsp_if
// Valid/ready channels for search requests and responses.
// ----------------------------------------------------------------------------
interface fgs_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  command;
	logic [11:0] entry_index;
	logic [63:0] key_value;

	modport source (output valid, output command, output entry_index, output key_value,
		input ready);
	modport sink (input valid, input command, input entry_index, input key_value,
		output ready);
endinterface

interface fgs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] found_index;

	modport source (output valid, output status, output found_index, input ready);
	modport sink (input valid, input status, input found_index, output ready);
endinterface

// File: rtl/fgs_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgs_apb_regs
// APB register file holding entry_count; flags each count write.
// ----------------------------------------------------------------------------
module fgs_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fgs_pkg::APB_AW-1:0]    paddr,
	input  logic [fgs_pkg::APB_DW-1:0]    pwdata,
	output logic [fgs_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output fgs_pkg::cfg_t                 cfg
);
	import fgs_pkg::*;

	logic [COUNT_W-1:0] count_q;
	reg_idx_t           reg_sel;
	logic               wr_en;

	// Word select; byte offset bits are ignored
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & (reg_sel == REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_ENTRY_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, count_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.wr    = wr_en;
	assign cfg.count = count_q;

endmodule

// File: rtl/finger_galloping_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finger_galloping_search
// Timestamp table with a finger-started galloping and bisection search.
// ----------------------------------------------------------------------------
// Write request: accepted while idle, no response; writes run back to back.
// Query: an empty table goes straight to the response; otherwise the start bracket
// is checked first, then the search gallops up or down and bisects the bracket,
// except when the start bracket holds the key or the gallop stops at an end entry.
// One request in flight; the next can be taken in the cycle after the response loads.
// Reset: count 0, bracket invalid; table contents undefined until written.
module finger_galloping_search #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fgs_req_if.sink                    req,
	fgs_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fgs_pkg::APB_AW-1:0] paddr,
	input  logic [fgs_pkg::APB_DW-1:0] pwdata,
	output logic [fgs_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import fgs_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned XW = AW + 2;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// Configuration
	cfg_t cfg;

	fgs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Table memory
	logic [KEY_W-1:0] table_mem [TABLE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;

	// Sequencer and datapath state
	state_t           state_q, state_nx;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    lo_q, hi_q, last_q, mid_q, res_q;
	logic [XW-1:0]    delta_q;
	status_t          sts_q;
	logic [AW-1:0]    lo_fing_q, hi_fing_q;
	logic             fing_valid_q;
	logic             out_valid_q;
	status_t          out_sts_q;
	logic [IDX_W-1:0] out_idx_q;

	// Derived values
	logic             req_acc, is_query, wr_in_range;
	logic [AW+11:0]   wr_ext;
	logic [CW+12:0]   cnt_ext;
	logic [CW-1:0]    cnt_sat, cnt_m1;
	logic [AW-1:0]    last_init, half_init;
	logic             fing_ok;
	logic             key_lt;
	logic [XW-1:0]    up_sum, dn_diff, mid_sum;
	logic [AW-1:0]    up_hi, dn_lo, mid_nx;
	logic             out_free;
	logic [AW+11:0]   res_ext;

	assign req_acc  = req.valid & req.ready;
	assign is_query = (cmd_t'(req.command) == CMD_QUERY);

	// Write address and range check
	assign wr_ext      = {{AW{1'b0}}, req.entry_index};
	assign wr_addr     = wr_ext[AW-1:0];
	assign wr_in_range = ({20'd0, req.entry_index} < 32'(TABLE_DEPTH));
	assign wr_en       = req_acc & ~is_query & wr_in_range;

	// Used entries, saturated at the table depth
	assign cnt_ext   = {{CW{1'b0}}, cfg.count};
	assign cnt_sat   = ({19'd0, cfg.count} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
		: cnt_ext[CW-1:0];
	assign cnt_m1    = cnt_sat - CW'(1);
	assign last_init = cnt_m1[AW-1:0];
	assign half_init = AW'(cnt_sat >> 1);
	assign fing_ok   = fing_valid_q & (hi_fing_q <= last_init) & (lo_fing_q <= hi_fing_q);

	// Step arithmetic
	assign key_lt  = key_q < rd_data_q;
	assign up_sum  = XW'(hi_q) + delta_q;
	assign up_hi   = (up_sum > XW'(last_q)) ? last_q : up_sum[AW-1:0];
	assign dn_diff = XW'(lo_q) - delta_q;
	assign dn_lo   = (delta_q > XW'(lo_q)) ? '0 : dn_diff[AW-1:0];
	assign mid_sum = XW'(lo_q) + {1'b0, delta_q[XW-1:1]};
	assign mid_nx  = mid_sum[AW-1:0];

	assign out_free = ~out_valid_q | rsp.ready;
	assign res_ext  = {12'd0, res_q};

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= req.key_value;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && is_query) begin
					state_nx = (cnt_sat == '0) ? S_FIN : S_RD_HI;
				end
			end
			S_RD_HI:  state_nx = S_CHK_HI;
			S_CHK_HI: state_nx = (!key_lt && lo_q != last_q) ? S_UP : S_CHK_LO;
			S_CHK_LO: state_nx = key_lt ? S_DN : S_FIN;
			S_UP:     state_nx = S_UP_CHK;
			S_UP_CHK: begin
				if (key_lt) begin
					state_nx = S_BIS;
				end else if (hi_q == last_q) begin
					state_nx = S_FIN;
				end else begin
					state_nx = S_UP;
				end
			end
			S_DN:     state_nx = S_DN_CHK;
			S_DN_CHK: begin
				if (!key_lt) begin
					state_nx = S_BIS;
				end else if (lo_q == '0) begin
					state_nx = S_FIN;
				end else begin
					state_nx = S_DN;
				end
			end
			S_BIS:     state_nx = (delta_q > XW'(1)) ? S_BIS_CHK : S_FIN;
			S_BIS_CHK: state_nx = S_BIS;
			S_FIN:     state_nx = out_free ? S_IDLE : S_FIN;
			default:   state_nx = S_IDLE;
		endcase
	end

	// Outputs: request ready and the table read address
	always_comb begin
		req.ready = 1'b0;
		rd_addr   = hi_q;
		unique case (state_q)
			S_IDLE:   req.ready = 1'b1;
			S_RD_HI:  rd_addr = hi_q;
			S_CHK_HI: rd_addr = lo_q;
			S_UP:     rd_addr = up_hi;
			S_DN:     rd_addr = dn_lo;
			S_BIS:    rd_addr = mid_nx;
			default:  rd_addr = hi_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && is_query) begin
					key_q   <= req.key_value;
					last_q  <= last_init;
					delta_q <= XW'(1);
					sts_q   <= STS_EMPTY;
					res_q   <= '0;
					if (fing_ok) begin
						lo_q <= lo_fing_q;
						hi_q <= hi_fing_q;
					end else begin
						lo_q <= half_init;
						hi_q <= half_init;
					end
				end
			end
			S_CHK_LO: begin
				if (!key_lt) begin
					sts_q <= STS_FOUND;
					res_q <= lo_q;
				end
			end
			S_UP: begin
				lo_q    <= hi_q;
				hi_q    <= up_hi;
				delta_q <= XW'(up_hi) - XW'(hi_q);
			end
			S_UP_CHK: begin
				if (!key_lt) begin
					if (hi_q == last_q) begin
						lo_q  <= last_q;
						sts_q <= STS_FOUND;
						res_q <= last_q;
					end else begin
						delta_q <= {delta_q[XW-2:0], 1'b0};
					end
				end
			end
			S_DN: begin
				hi_q    <= lo_q;
				lo_q    <= dn_lo;
				delta_q <= XW'(lo_q) - XW'(dn_lo);
			end
			S_DN_CHK: begin
				if (key_lt) begin
					if (lo_q == '0) begin
						hi_q  <= '0;
						sts_q <= STS_BEFORE;
						res_q <= '0;
					end else begin
						delta_q <= {delta_q[XW-2:0], 1'b0};
					end
				end
			end
			S_BIS: begin
				mid_q <= mid_nx;
				if (delta_q <= XW'(1)) begin
					sts_q <= STS_FOUND;
					res_q <= lo_q;
				end
			end
			S_BIS_CHK: begin
				if (key_lt) begin
					hi_q    <= mid_q;
					delta_q <= XW'(mid_q) - XW'(lo_q);
				end else begin
					lo_q    <= mid_q;
					delta_q <= XW'(hi_q) - XW'(mid_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Finger bracket: saved after each non-empty query, dropped on any change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_fing_q    <= '0;
			hi_fing_q    <= '0;
			fing_valid_q <= 1'b0;
		end else if (cfg.wr || wr_en) begin
			fing_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free && sts_q != STS_EMPTY) begin
			lo_fing_q    <= lo_q;
			hi_fing_q    <= hi_q;
			fing_valid_q <= 1'b1;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_sts_q <= sts_q;
			out_idx_q <= res_ext[IDX_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_sts_q;
	assign rsp.found_index = out_idx_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finger_galloping_search testbench
// Loads timestamp tables through write requests and runs lookups under several
// entry counts, including empty, single entry and partly used tables. A short
// directed table comes first, then random phases with mostly sorted tables and
// keys clustered near the last lookup. Every lookup response is checked against
// a behavioral galloping search that tracks the block's bracket state, or a
// directed row's result; the count register is read back after every write.
// ----------------------------------------------------------------------------
module testbench;
	import fgs_pkg::*;

	localparam int TABLE_DEPTH   = 4096;
	localparam int LOAD_ENTRIES  = 1024;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 80;
	localparam int N_PHASES      = 12;
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	typedef enum bit {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cmd_t        cmd;
		logic [11:0] pos;
		logic [63:0] val;
		bit          typed;
		status_t     st;
		logic [11:0] fidx;
	} plan_row_t;

	typedef struct packed {
		status_t     st;
		logic [11:0] pos;
	} answer_t;

	logic clk;
	logic arst_n;
	fgs_req_if req_ch();
	fgs_rsp_if rsp_ch();
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Typed expectation that travels with the current request
	bit          row_typed;
	status_t     row_st;
	logic [11:0] row_fidx;

	// Mirror of the block state, owned by the checker process
	logic [63:0] ts_table [TABLE_DEPTH];
	logic [11:0] fing_lo = '0;
	logic [11:0] fing_hi = '0;
	bit          fing_ok = 1'b0;
	logic [COUNT_W-1:0] count_reg = '0;
	answer_t     pending [$];

	// Stimulus-side view of the table, used only to pick values and keys
	logic [63:0] stim_table [TABLE_DEPTH];

	int  mismatches = 0;
	int  n_lookups = 0;
	int  n_writes = 0;
	int  n_answers = 0;
	int  n_cfg = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;

	plan_row_t plan [25] = '{
		// empty table after reset
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd0,    1'b1, STS_EMPTY,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    ALL_ONES, 1'b1, STS_EMPTY,  12'd0},
		// small sorted table with a duplicate, plus the top entry
		'{ROW_REQ, CMD_WRITE, 12'd0,    64'd5,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_WRITE, 12'd1,    64'd10,   1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_WRITE, 12'd2,    64'd10,   1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_WRITE, 12'd3,    64'd20,   1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_WRITE, 12'd4095, ALL_ONES, 1'b0, STS_FOUND,  12'd0},
		'{ROW_CFG, CMD_WRITE, 12'd0,    64'd4,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd4,    1'b1, STS_BEFORE, 12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd0,    1'b1, STS_BEFORE, 12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd5,    1'b1, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd10,   1'b1, STS_FOUND,  12'd2},
		'{ROW_REQ, CMD_QUERY, 12'd0,    ALL_ONES, 1'b1, STS_FOUND,  12'd3},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd15,   1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd19,   1'b0, STS_FOUND,  12'd0},
		// single entry
		'{ROW_CFG, CMD_WRITE, 12'd0,    64'd1,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd5,    1'b1, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd4,    1'b1, STS_BEFORE, 12'd0},
		// break the ordering, then search it
		'{ROW_REQ, CMD_WRITE, 12'd2,    64'd3,    1'b0, STS_FOUND,  12'd0},
		'{ROW_CFG, CMD_WRITE, 12'd0,    64'd4,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd10,   1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd3,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd25,   1'b0, STS_FOUND,  12'd0},
		// count back to zero
		'{ROW_CFG, CMD_WRITE, 12'd0,    64'd0,    1'b0, STS_FOUND,  12'd0},
		'{ROW_REQ, CMD_QUERY, 12'd0,    64'd7,    1'b1, STS_EMPTY,  12'd0}
	};

	// Phase entry counts; phase 7 draws a random count
	int unsigned phase_count [N_PHASES] = '{1024, 2, 1, 1023, 1000, 3, 0, 0,
		511, 17, 512, 1024};

	finger_galloping_search DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
	endtask

	// Galloping search from the saved bracket, then bisection
	function automatic void gallop_predict(input logic [63:0] key, output status_t st,
		output logic [11:0] pos);
		int cnt;
		int last;
		int lo;
		int hi;
		int dir;
		int delta;
		int res;
		int mid;
		cnt = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
		if (cnt == 0) begin
			st = STS_EMPTY;
			pos = '0;
			return;
		end
		last = cnt - 1;
		lo = fing_lo;
		hi = fing_hi;
		// no bracket or a bracket past the used entries: start mid-table
		if (!fing_ok || hi > last || lo > hi) begin
			lo = cnt / 2;
			hi = lo;
		end
		res = -2;
		delta = 1;
		if (key >= ts_table[hi] && lo != last) dir = 1;
		else if (key < ts_table[lo]) dir = -1;
		else begin
			dir = 0;
			res = lo;
		end
		// gallop up
		while (dir > 0) begin
			lo = hi;
			hi = (hi + delta > last) ? last : hi + delta;
			delta = hi - lo;
			if (key < ts_table[hi]) dir = 0;
			else if (hi == last) begin
				lo = last;
				res = last;
				dir = 0;
			end else delta = delta * 2;
		end
		// gallop down
		while (dir < 0) begin
			hi = lo;
			lo = (lo - delta < 0) ? 0 : lo - delta;
			delta = hi - lo;
			if (key >= ts_table[lo]) dir = 0;
			else if (lo == 0) begin
				hi = 0;
				res = -1;
				dir = 0;
			end else delta = delta * 2;
		end
		// bisect inside the bracket
		if (res == -2) begin
			while (delta > 1) begin
				mid = lo + delta / 2;
				if (key < ts_table[mid]) hi = mid;
				else lo = mid;
				delta = hi - lo;
			end
			res = lo;
		end
		fing_lo = lo[11:0];
		fing_hi = hi[11:0];
		fing_ok = 1'b1;
		if (res < 0) begin
			st = STS_BEFORE;
			pos = '0;
		end else begin
			st = STS_FOUND;
			pos = res[11:0];
		end
	endfunction

	// Checker: mirrors accepted writes, predicts accepted lookups, compares accepted responses and readback
	always @(posedge clk) begin
		status_t     st;
		logic [11:0] pos;
		answer_t     want;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (req_ch.command == CMD_WRITE) begin
				ts_table[req_ch.entry_index] = req_ch.key_value;
				fing_ok = 1'b0;
				n_writes++;
			end else begin
				gallop_predict(req_ch.key_value, st, pos);
				if (row_typed) begin
					st = row_st;
					pos = row_fidx;
				end
				pending.push_back(answer_t'{st, pos});
				n_lookups++;
			end
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_answers++;
			if (pending.size() == 0)
				note_mismatch("unexpected response status", '0, rsp_ch.status);
			else begin
				want = pending.pop_front();
				if (rsp_ch.status !== want.st)
					note_mismatch("status", want.st, rsp_ch.status);
				if (rsp_ch.found_index !== want.pos)
					note_mismatch("found_index", want.pos, rsp_ch.found_index);
			end
		end
		// configuration port
		if (arst_n && psel && penable && pready) begin
			if (pwrite) begin
				if (paddr[2] == REG_ENTRY_COUNT) begin
					count_reg = pwdata[COUNT_W-1:0];
					fing_ok = 1'b0;
					n_cfg++;
				end
			end else if (prdata !== {{(APB_DW-COUNT_W){1'b0}}, count_reg})
				note_mismatch("entry_count readback", count_reg, prdata);
		end
	end

	// Watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("finger_galloping_search regression: fail");
			$finish;
		end
	end

	// Response side: random stall bursts unless calm
	initial begin
		rsp_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Send one request; returns at the edge where it was accepted
	task automatic issue(cmd_t c, logic [11:0] p, logic [63:0] v, bit typed,
		status_t s, logic [11:0] fi);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= c;
		req_ch.entry_index <= p;
		req_ch.key_value   <= v;
		row_typed          <= typed;
		row_st             <= s;
		row_fidx           <= fi;
		if (c == CMD_WRITE) stim_table[p] = v;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Hold requests until every lookup is answered and the block settles
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer; psel stays high so transfers can run back to back
	task automatic apb_xfer(bit wr, logic [APB_DW-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_ENTRY_COUNT, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_count(int unsigned c);
		drain();
		apb_xfer(1'b1, APB_DW'(c));
		apb_xfer(1'b0, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus
	initial begin
		int          eff;
		int          prev_idx;
		int          idx;
		int          off;
		int          mode;
		logic [63:0] cur;
		logic [63:0] step;
		logic [63:0] lo_v;
		logic [63:0] hi_v;
		logic [63:0] span;
		logic [63:0] v;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.command     <= CMD_WRITE;
		req_ch.entry_index <= '0;
		req_ch.key_value   <= '0;
		row_typed          <= 1'b0;
		row_st             <= STS_FOUND;
		row_fidx           <= '0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				set_count(int'(plan[i].val));
			else
				issue(plan[i].cmd, plan[i].pos, plan[i].val, plan[i].typed,
					plan[i].st, plan[i].fidx);
		end

		// load the lower part of the table in order: duplicates, small and large steps
		cur = 64'($urandom_range(0, 1000));
		for (int i = 0; i < LOAD_ENTRIES; i++) begin
			mode = $urandom_range(0, 3);
			if (mode == 0) step = '0;
			else if (mode == 1) step = 64'($urandom_range(1, 16));
			else step = rand64() >> $urandom_range(12, 32);
			cur = (cur + step < cur) ? ALL_ONES : cur + step;
			if (i == 0 && $urandom_range(0, 1) == 0) cur = '0;
			issue(CMD_WRITE, i[11:0], cur, 1'b0, STS_FOUND, '0);
		end

		// random phases over several counts
		prev_idx = 0;
		for (int p = 0; p < N_PHASES; p++) begin
			set_count((p == 7) ? $urandom_range(5, LOAD_ENTRIES - 2) : phase_count[p]);
			eff = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
			calm = (p == N_PHASES - 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 4 && k == 40) drain();
				if ($urandom_range(0, 99) < 8) begin
					// table write, mostly keeping the order intact
					idx = $urandom_range(0, LOAD_ENTRIES - 1);
					lo_v = (idx > 0) ? stim_table[idx - 1] : '0;
					hi_v = (idx < LOAD_ENTRIES - 1) ? stim_table[idx + 1] : ALL_ONES;
					span = hi_v - lo_v;
					if ($urandom_range(0, 9) == 0) v = rand64();
					else if (hi_v < lo_v) v = lo_v;
					else if (span == ALL_ONES) v = rand64();
					else v = lo_v + rand64() % (span + 1);
					issue(CMD_WRITE, idx[11:0], v, 1'b0, STS_FOUND, '0);
				end else begin
					mode = $urandom_range(0, 9);
					if (eff == 0 || mode < 2) v = rand64();
					else if (mode == 2) v = $urandom_range(0, 1) ? ALL_ONES : '0;
					else begin
						// keys near the previous lookup exercise the bracket reuse
						if (mode <= 6) begin
							off = $urandom_range(0, 1) ? $urandom_range(0, 4)
								: $urandom_range(0, 64);
							idx = $urandom_range(0, 1) ? prev_idx + off : prev_idx - off;
							if (idx < 0) idx = 0;
							if (idx > eff - 1) idx = eff - 1;
						end else
							idx = $urandom_range(0, eff - 1);
						prev_idx = idx;
						v = stim_table[idx];
						case ($urandom_range(0, 3))
							0: v = v - 1;
							3: v = v + 1;
							default: ;
						endcase
					end
					issue(CMD_QUERY, 12'($urandom), v, 1'b0, STS_FOUND, '0);
				end
			end
		end

		drain();
		if (pending.size() != 0)
			note_mismatch("responses missing", 0, pending.size());
		$display("Covered %0d table writes and %0d lookups (%0d answered) over %0d count settings.",
			n_writes, n_lookups, n_answers, n_cfg);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("finger_galloping_search regression: pass");
		else
			$display("finger_galloping_search regression: fail");
		$finish;
	end

endmodule
